### sv/ghlc_pkg.sv
// Shared constants, types and a helper function of the Hamming leader clusterer.
`timescale 1ns / 1ps
`default_nettype none

package ghlc_pkg;

  localparam int unsigned MAX_CENTERS = 1024;
  localparam int unsigned IDX_W       = $clog2(MAX_CENTERS);
  localparam int unsigned CNT_W       = $clog2(MAX_CENTERS + 1);
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned NUM_WORDS   = 4;
  localparam int unsigned HASH_W      = WORD_W * NUM_WORDS;
  localparam int unsigned POP_W       = $clog2(WORD_W + 1);
  localparam int unsigned DIST_W      = 9;
  localparam int unsigned CLUSTER_W   = 10;
  localparam logic [DIST_W-1:0] THRESHOLD_RESET = DIST_W'(31);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DELIVER
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;       // capture the hash, rewind the scan
    logic scan;        // issue reads while centres remain
    logic take_match;  // latch the matching centre as the result
    logic take_miss;   // store a new centre or flag a full table
    logic load_out;    // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;       // the centre leaving the pipeline is within reach
    logic scan_done;   // every stored centre compared, pipeline empty
    logic out_free;    // output register can take a result this cycle
  } stat_t;

  // Population count of one word: count each byte, then add the bytes.
  function automatic logic [POP_W-1:0] popcount_word(input logic [WORD_W-1:0] v);
    logic [3:0]       byte_cnt [WORD_W/8];
    logic [POP_W-1:0] sum;
    sum = '0;
    for (int b = 0; b < WORD_W / 8; b++) begin
      byte_cnt[b] = '0;
      for (int k = 0; k < 8; k++) begin
        byte_cnt[b] = byte_cnt[b] + 4'(v[b*8+k]);
      end
    end
    for (int b = 0; b < WORD_W / 8; b++) begin
      sum = sum + POP_W'(byte_cnt[b]);
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

### sv/greedy_hamming_leader_clusterer.sv
// Top level of the greedy leader clusterer over 256-bit hashes by Hamming distance.
// Usage:
//   Input channel: in_valid_i with hash_word0_i..hash_word3_i; a transaction
//   completes when in_valid_i is high and in_stall_o low. One hash at a time.
//   Output channel: out_valid_o with the result fields; a transaction completes
//   when out_valid_o is high and out_stall_i low. Exactly one result per hash.
//   Config channel: cfg_valid_i/cfg_ready_o carry the 9-bit distance threshold
//   in cfg_data_i (reset value 31); write it only while the block is idle.
// Timing:
//   A hash is compared with the stored centres one per cycle through the
//   single read port of the centre memory, in storage order, stopping at the
//   first centre within the threshold. The scan runs through a read stage and a
//   popcount stage; the next hash is not taken until the result has moved
//   into the output register.
// Reset: the centre count clears at once and the threshold returns to 31;
//   the centre memory is not cleared, as only written entries are ever compared.
// Stall: a result waits in the output register while out_stall_i is high;
//   the next hash may be accepted and scanned meanwhile, and its result is
//   held back until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module greedy_hamming_leader_clusterer (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [ghlc_pkg::WORD_W-1:0]   hash_word0_i,
  input  wire logic [ghlc_pkg::WORD_W-1:0]   hash_word1_i,
  input  wire logic [ghlc_pkg::WORD_W-1:0]   hash_word2_i,
  input  wire logic [ghlc_pkg::WORD_W-1:0]   hash_word3_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [ghlc_pkg::CLUSTER_W-1:0]     cluster_index_o,
  output logic                               is_center_o,
  output logic [ghlc_pkg::DIST_W-1:0]        distance_o,
  output logic [ghlc_pkg::WORD_W-1:0]        center_word0_o,
  output logic [ghlc_pkg::WORD_W-1:0]        center_word1_o,
  output logic [ghlc_pkg::WORD_W-1:0]        center_word2_o,
  output logic [ghlc_pkg::WORD_W-1:0]        center_word3_o,
  output logic                               table_full_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [ghlc_pkg::DIST_W-1:0]   cfg_data_i
);
  import ghlc_pkg::*;

  cmd_t              cmd;
  stat_t             stat;
  logic [HASH_W-1:0] hash;
  logic [HASH_W-1:0] center;

  // The threshold register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // Assemble the hash, lowest word in the lowest bits.
  assign hash = {hash_word3_i, hash_word2_i, hash_word1_i, hash_word0_i};

  ghlc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ghlc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .cfg_data_i      (cfg_data_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .hash_i          (hash),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .cluster_index_o (cluster_index_o),
    .is_center_o     (is_center_o),
    .distance_o      (distance_o),
    .center_o        (center),
    .table_full_o    (table_full_o)
  );

  // Split the chosen centre back into its words.
  assign center_word0_o = center[0*WORD_W +: WORD_W];
  assign center_word1_o = center[1*WORD_W +: WORD_W];
  assign center_word2_o = center[2*WORD_W +: WORD_W];
  assign center_word3_o = center[3*WORD_W +: WORD_W];

endmodule

`default_nettype wire

### sv/ghlc_ctrl.sv
// Controller state machine: sequences accept, scan, result capture and delivery.
`timescale 1ns / 1ps
`default_nettype none

module ghlc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire ghlc_pkg::stat_t stat_i,
  output ghlc_pkg::cmd_t     cmd_o
);
  import ghlc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.match || stat_i.scan_done) state_d = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.start = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan       = 1'b1;
        cmd_o.take_match = stat_i.match;
        cmd_o.take_miss  = !stat_i.match && stat_i.scan_done;
      end
      ST_DELIVER: begin
        cmd_o.load_out = stat_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/ghlc_dp.sv
// Datapath: centre memory, distance pipeline, centre count, result and output registers.
`timescale 1ns / 1ps
`default_nettype none

module ghlc_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire ghlc_pkg::cmd_t                  cmd_i,
  output ghlc_pkg::stat_t                      stat_o,
  input  wire logic [ghlc_pkg::DIST_W-1:0]     cfg_data_i,
  input  wire logic                            cfg_we_i,
  input  wire logic [ghlc_pkg::HASH_W-1:0]     hash_i,
  input  wire logic                            out_stall_i,
  output logic                                 out_valid_o,
  output logic [ghlc_pkg::CLUSTER_W-1:0]       cluster_index_o,
  output logic                                 is_center_o,
  output logic [ghlc_pkg::DIST_W-1:0]          distance_o,
  output logic [ghlc_pkg::HASH_W-1:0]          center_o,
  output logic                                 table_full_o
);
  import ghlc_pkg::*;

  // Centre memory, one full hash per entry.
  logic [HASH_W-1:0] mem_q [MAX_CENTERS];

  logic [DIST_W-1:0] thr_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  rd_idx_q;
  logic [HASH_W-1:0] hash_q;

  // Pipeline: read stage, popcount stage.
  logic              v1_q, v2_q;
  logic [CNT_W-1:0]  idx1_q, idx2_q;
  logic [HASH_W-1:0] rdata_q, data2_q;
  logic [POP_W-1:0]  pc_q [NUM_WORDS];

  // Held result, then output register.
  logic [CLUSTER_W-1:0] res_idx_q;
  logic                 res_new_q;
  logic [DIST_W-1:0]    res_dist_q;
  logic [HASH_W-1:0]    res_center_q;
  logic                 res_full_q;
  logic                 out_valid_q;

  logic              issue;
  logic              full;
  logic              wr_en;
  logic [DIST_W-1:0] hamming;

  assign issue = cmd_i.scan && (rd_idx_q < count_q);
  assign full  = (count_q >= CNT_W'(MAX_CENTERS));
  assign wr_en = cmd_i.take_miss && !full;

  always_comb begin
    hamming = '0;
    for (int w = 0; w < NUM_WORDS; w++) begin
      hamming = hamming + DIST_W'(pc_q[w]);
    end
  end

  assign stat_o.match     = v2_q && (hamming <= thr_q);
  assign stat_o.scan_done = (rd_idx_q >= count_q) && !v1_q && !v2_q;
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[count_q[IDX_W-1:0]] <= hash_q;
    end
    rdata_q <= mem_q[rd_idx_q[IDX_W-1:0]];
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= THRESHOLD_RESET;
      count_q     <= '0;
      rd_idx_q    <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) thr_q <= cfg_data_i;
      if (wr_en)    count_q <= count_q + CNT_W'(1);
      if (cmd_i.start) begin
        rd_idx_q <= '0;
        v1_q     <= 1'b0;
        v2_q     <= 1'b0;
      end else begin
        if (issue) rd_idx_q <= rd_idx_q + CNT_W'(1);
        v1_q <= issue;
        v2_q <= v1_q;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) hash_q <= hash_i;
    idx1_q  <= rd_idx_q;
    idx2_q  <= idx1_q;
    data2_q <= rdata_q;
    for (int w = 0; w < NUM_WORDS; w++) begin
      pc_q[w] <= popcount_word(hash_q[w*WORD_W +: WORD_W] ^ rdata_q[w*WORD_W +: WORD_W]);
    end
    if (cmd_i.take_match) begin
      res_idx_q    <= CLUSTER_W'(idx2_q);
      res_new_q    <= 1'b0;
      res_dist_q   <= hamming;
      res_center_q <= data2_q;
      res_full_q   <= 1'b0;
    end else if (cmd_i.take_miss) begin
      if (full) begin
        res_idx_q    <= '0;
        res_new_q    <= 1'b0;
        res_dist_q   <= '0;
        res_center_q <= '0;
        res_full_q   <= 1'b1;
      end else begin
        res_idx_q    <= CLUSTER_W'(count_q);
        res_new_q    <= 1'b1;
        res_dist_q   <= '0;
        res_center_q <= hash_q;
        res_full_q   <= 1'b0;
      end
    end
    if (cmd_i.load_out) begin
      cluster_index_o <= res_idx_q;
      is_center_o     <= res_new_q;
      distance_o      <= res_dist_q;
      center_o        <= res_center_q;
      table_full_o    <= res_full_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### tb/tb_greedy_hamming_leader_clusterer.sv
// Self-checking testbench of the greedy Hamming leader clusterer.
`timescale 1ns / 1ps

module tb_greedy_hamming_leader_clusterer;
  import ghlc_pkg::*;

  localparam logic [HASH_W-1:0] ALL_ONES = {HASH_W{1'b1}};
  localparam int unsigned NUM_PHASES       = 7;
  localparam int unsigned ITEMS_PER_PHASE  = 80;
  localparam int unsigned LONG_HOLD_CYCLES = 2000;
  localparam int unsigned HOLD_AFTER       = 60;   // results seen before the long hold
  localparam int unsigned SETTLE_CYCLES    = 20;

  // Kinds of row in the directed plan.
  typedef enum logic {
    ROW_HASH,
    ROW_CFG
  } row_kind_e;

  // Ways of building a random hash.
  typedef enum logic [1:0] {
    GEN_NEAR,
    GEN_EXTREME,
    GEN_FRESH
  } gen_kind_e;

  // One result transaction, field for field as the block reports it.
  typedef struct packed {
    logic [CLUSTER_W-1:0] idx;
    logic                 made_new;
    logic [DIST_W-1:0]    hamming;
    logic [HASH_W-1:0]    center;
    logic                 full;
  } lookup_t;

  typedef struct packed {
    row_kind_e         kind;
    logic [HASH_W-1:0] hash;
    logic [DIST_W-1:0] limit;
    logic              typed;
    lookup_t           want;
  } drow_t;

  // Clock, reset and the block's ports.
  logic                 clk_i = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 hash_valid = 1'b0;
  logic                 hash_stall;
  logic [WORD_W-1:0]    hw0 = '0;
  logic [WORD_W-1:0]    hw1 = '0;
  logic [WORD_W-1:0]    hw2 = '0;
  logic [WORD_W-1:0]    hw3 = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [CLUSTER_W-1:0] got_index;
  logic                 got_is_center;
  logic [DIST_W-1:0]    got_dist;
  logic [WORD_W-1:0]    got_c0;
  logic [WORD_W-1:0]    got_c1;
  logic [WORD_W-1:0]    got_c2;
  logic [WORD_W-1:0]    got_c3;
  logic                 got_full;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [DIST_W-1:0]    cfg_data = '0;

  // Predictor state: our own copy of the centre table and the threshold.
  logic [HASH_W-1:0] center_table [MAX_CENTERS];
  int unsigned       centers_held = 0;
  int unsigned       join_limit   = 31;

  lookup_t     pending_results [$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;

  greedy_hamming_leader_clusterer DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (hash_valid),
    .in_stall_o      (hash_stall),
    .hash_word0_i    (hw0),
    .hash_word1_i    (hw1),
    .hash_word2_i    (hw2),
    .hash_word3_i    (hw3),
    .out_valid_o     (result_valid),
    .out_stall_i     (result_stall),
    .cluster_index_o (got_index),
    .is_center_o     (got_is_center),
    .distance_o      (got_dist),
    .center_word0_o  (got_c0),
    .center_word1_o  (got_c1),
    .center_word2_o  (got_c2),
    .center_word3_o  (got_c3),
    .table_full_o    (got_full),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Scan the table in storage order; the first centre within reach wins.
  // On a miss, store the hash as a new centre, or flag a full table.
  function automatic lookup_t cluster_lookup(input logic [HASH_W-1:0] h);
    lookup_t     res;
    int unsigned d;
    bit          hit;
    res = '0;
    hit = 1'b0;
    for (int unsigned i = 0; i < centers_held && !hit; i++) begin
      d = $countones(h ^ center_table[i]);
      if (d <= join_limit) begin
        res.idx     = CLUSTER_W'(i);
        res.hamming = DIST_W'(d);
        res.center  = center_table[i];
        hit         = 1'b1;
      end
    end
    if (!hit) begin
      if (centers_held >= MAX_CENTERS) begin
        res.full = 1'b1;
      end else begin
        center_table[centers_held] = h;
        res.idx      = CLUSTER_W'(centers_held);
        res.made_new = 1'b1;
        res.center   = h;
        centers_held = centers_held + 1;
      end
    end
    return res;
  endfunction

  function automatic logic [HASH_W-1:0] fresh_hash();
    logic [HASH_W-1:0] h;
    for (int k = 0; k < HASH_W / 32; k++) begin
      h[k*32 +: 32] = $urandom;
    end
    return h;
  endfunction

  function automatic drow_t hash_row(input logic [HASH_W-1:0] h, input logic typed,
                                     input lookup_t want);
    drow_t r;
    r       = '0;
    r.kind  = ROW_HASH;
    r.hash  = h;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic drow_t cfg_row(input logic [DIST_W-1:0] v);
    drow_t r;
    r       = '0;
    r.kind  = ROW_CFG;
    r.limit = v;
    return r;
  endfunction

  // One line per mismatch; keep counting and carry on.
  task automatic report_mismatch(input string field, input logic [HASH_W-1:0] got,
                                 input logic [HASH_W-1:0] want);
    mismatches = mismatches + 1;
    $display("%0t ns: %s got %h want %h", $time, field, got, want);
  endtask

  // Offer one hash after a random gap, hold it until accepted, then predict.
  // A typed expectation replaces the prediction but the table still advances.
  task automatic offer_hash(input logic [HASH_W-1:0] h, input logic typed,
                            input lookup_t want);
    int unsigned r;
    int unsigned gap;
    lookup_t     predicted;
    r = $urandom_range(0, 99);
    if (r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 60);
    if (gap != 0) begin
      hash_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    hash_valid <= 1'b1;
    hw0 <= h[0*WORD_W +: WORD_W];
    hw1 <= h[1*WORD_W +: WORD_W];
    hw2 <= h[2*WORD_W +: WORD_W];
    hw3 <= h[3*WORD_W +: WORD_W];
    do @(posedge clk_i); while (hash_stall);
    predicted = cluster_lookup(h);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Drop valid and hold off until every expected result has come back.
  task automatic settle();
    hash_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write the threshold while the block is idle.
  task automatic set_join_limit(input logic [DIST_W-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    join_limit = v;
  endtask

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    lookup_t want;
    if (rst_n && result_valid && !result_stall) begin
      results_seen = results_seen + 1;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, cluster_index", HASH_W'(got_index), '0);
      end else begin
        want = pending_results.pop_front();
        if (got_index !== want.idx)
          report_mismatch("cluster_index", HASH_W'(got_index), HASH_W'(want.idx));
        if (got_is_center !== want.made_new)
          report_mismatch("new centre flag", HASH_W'(got_is_center),
                          HASH_W'(want.made_new));
        if (got_dist !== want.hamming)
          report_mismatch("distance", HASH_W'(got_dist), HASH_W'(want.hamming));
        if (got_c0 !== want.center[0*WORD_W +: WORD_W])
          report_mismatch("center_word0", HASH_W'(got_c0),
                          HASH_W'(want.center[0*WORD_W +: WORD_W]));
        if (got_c1 !== want.center[1*WORD_W +: WORD_W])
          report_mismatch("center_word1", HASH_W'(got_c1),
                          HASH_W'(want.center[1*WORD_W +: WORD_W]));
        if (got_c2 !== want.center[2*WORD_W +: WORD_W])
          report_mismatch("center_word2", HASH_W'(got_c2),
                          HASH_W'(want.center[2*WORD_W +: WORD_W]));
        if (got_c3 !== want.center[3*WORD_W +: WORD_W])
          report_mismatch("center_word3", HASH_W'(got_c3),
                          HASH_W'(want.center[3*WORD_W +: WORD_W]));
        if (got_full !== want.full)
          report_mismatch("table_full", HASH_W'(got_full), HASH_W'(want.full));
      end
    end
  end

  // Receiver side: random stalls, mostly short, a few long, with free-running
  // stretches between them. Once, hold off for a long stretch so that the
  // block fills up and stalls its input.
  initial begin : result_stall_gen
    int unsigned r;
    int unsigned len;
    bit          long_hold_done;
    long_hold_done = 1'b0;
    @(posedge rst_n);
    @(posedge clk_i);
    forever begin
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        result_stall   <= 1'b1;
        len            = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          result_stall <= 1'b0;
          len = $urandom_range(1, 30);
        end else if (r < 90) begin
          result_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          result_stall <= 1'b1;
          len = $urandom_range(10, 60);
        end
      end
      repeat (len) @(posedge clk_i);
    end
  end

  // Stimulus: directed plan, then random phases over several thresholds.
  initial begin : stimulus
    drow_t             plan [$];
    logic [DIST_W-1:0] phase_limits [NUM_PHASES];
    logic [HASH_W-1:0] h;
    gen_kind_e         gen;
    int unsigned       r;
    int unsigned       kmax;
    int unsigned       flips;

    phase_limits = '{9'd31, 9'd0, 9'd200, 9'd256, 9'd511, 9'd7, 9'd128};

    // Reset threshold 31: empty table, extremes, the threshold boundary.
    plan.push_back(hash_row('0, 1'b1, lookup_t'{10'd0, 1'b1, 9'd0, 256'd0, 1'b0}));
    plan.push_back(hash_row(ALL_ONES, 1'b1,
                            lookup_t'{10'd1, 1'b1, 9'd0, ALL_ONES, 1'b0}));
    plan.push_back(hash_row('0, 1'b1, lookup_t'{10'd0, 1'b0, 9'd0, 256'd0, 1'b0}));
    plan.push_back(hash_row(256'h7FFF_FFFF, 1'b1,
                            lookup_t'{10'd0, 1'b0, 9'd31, 256'd0, 1'b0}));
    plan.push_back(hash_row(256'hFFFF_FFFF, 1'b1,
                            lookup_t'{10'd2, 1'b1, 9'd0, 256'hFFFF_FFFF, 1'b0}));
    // Equally close to two centres: the earlier one wins.
    plan.push_back(hash_row(256'hFFFF, 1'b1, lookup_t'{10'd0, 1'b0, 9'd16, 256'd0, 1'b0}));
    plan.push_back(hash_row({1'b0, {(HASH_W-1){1'b1}}}, 1'b1,
                            lookup_t'{10'd1, 1'b0, 9'd1, ALL_ONES, 1'b0}));
    plan.push_back(hash_row({{WORD_W{1'b1}}, {(3*WORD_W){1'b0}}}, 1'b0, '0));
    plan.push_back(hash_row({{WORD_W{1'b0}}, {WORD_W{1'b1}}, {(2*WORD_W){1'b0}}}, 1'b0, '0));
    plan.push_back(hash_row({{(2*WORD_W){1'b0}}, {WORD_W{1'b1}}, {WORD_W{1'b0}}}, 1'b0, '0));
    plan.push_back(hash_row({(HASH_W/4){4'hA}}, 1'b0, '0));
    plan.push_back(hash_row({(HASH_W/4){4'h5}}, 1'b0, '0));
    // Threshold zero: only exact copies join.
    plan.push_back(cfg_row(9'd0));
    plan.push_back(hash_row(256'h1, 1'b0, '0));
    plan.push_back(hash_row({(HASH_W/4){4'hA}}, 1'b0, '0));
    // Threshold 256 and above: the first centre always matches.
    plan.push_back(cfg_row(9'd256));
    plan.push_back(hash_row({(HASH_W/16){16'hDEAD}} ^ 256'h1234_5678, 1'b0, '0));
    plan.push_back(hash_row(ALL_ONES, 1'b1, lookup_t'{10'd0, 1'b0, 9'd256, 256'd0, 1'b0}));
    plan.push_back(cfg_row(9'd511));
    plan.push_back(hash_row({(HASH_W/4){4'h5}}, 1'b0, '0));
    plan.push_back(cfg_row(9'd31));
    plan.push_back(hash_row(ALL_ONES, 1'b1, lookup_t'{10'd1, 1'b0, 9'd0, ALL_ONES, 1'b0}));

    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) set_join_limit(plan[i].limit);
      else offer_hash(plan[i].hash, plan[i].typed, plan[i].want);
    end

    // Random phases: up to half are near copies of stored centres, which keep the
    // table small and probe the threshold from both sides.
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_join_limit(phase_limits[p]);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r = $urandom_range(0, 99);
        if (r < 50 && centers_held != 0) gen = GEN_NEAR;
        else if (r < 62) gen = GEN_EXTREME;
        else gen = GEN_FRESH;
        case (gen)
          GEN_NEAR: begin
            h     = center_table[$urandom_range(0, centers_held - 1)];
            kmax  = (join_limit + 6 > HASH_W) ? HASH_W : join_limit + 6;
            flips = $urandom_range(0, kmax);
            repeat (flips) h[$urandom_range(0, HASH_W - 1)] ^= 1'b1;
          end
          GEN_EXTREME: begin
            case ($urandom_range(0, 3))
              0: h = '0;
              1: h = ALL_ONES;
              2: begin
                h = '0;
                h[$urandom_range(0, 3)*WORD_W +: WORD_W] = {$urandom, $urandom};
              end
              default: begin
                h = fresh_hash();
                h[$urandom_range(0, 3)*WORD_W +: WORD_W] = {WORD_W{1'b1}};
              end
            endcase
          end
          default: h = fresh_hash();
        endcase
        offer_hash(h, 1'b0, '0);
        // Pause once mid-phase until the block has drained.
        if (p == 0 && n == ITEMS_PER_PHASE / 2) settle();
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin : watchdog
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
sv/ghlc_pkg.sv
sv/ghlc_ctrl.sv
sv/ghlc_dp.sv
sv/greedy_hamming_leader_clusterer.sv
tb/tb_greedy_hamming_leader_clusterer.sv
